// ----- design/dam_pkg.sv -----
// Package with shared constants and types of the dirty area merge block.
package dam_pkg;

  localparam int unsigned MaxAreas = 8;
  localparam int unsigned CoordBits = 11;
  localparam int unsigned IdxBits = $clog2(MaxAreas);
  localparam int unsigned CntBits = $clog2(MaxAreas + 1);
  localparam int unsigned RowsBits = 12;
  localparam int unsigned QueueDepth = 2;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdFetch = 1'b1;

  localparam logic [0:0] RegRenderMode = 1'b0;
  localparam logic [0:0] RegMaxRows = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } rect_t;

  typedef struct packed {
    logic  fetch;
    rect_t rect;
  } item_t;

  typedef enum logic [2:0] {
    StIdle,
    StJoinRead,
    StJoinTest,
    StFind,
    StEmit
  } back_state_e;

endpackage

// ----- design/dirty_area_merge_and_band.sv -----
// Top level of the dirty area merge and refresh banding block.
//
// Channel | Direction | Handshake          | Payload
// command | in        | start / busy       | cmd_i, rect_x1_i .. rect_y2_i
// window  | out       | strobe_o, one shot | win_x1_o .. win_y2_o, win_valid_o, win_last_o
// config  | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// An idle back end stores an add, if it holds fewer than eight areas, in the cycle
// after its transfer. The first fetch that finds areas after reset or a last window
// runs the join pass over ordered pairs of areas, which share the single size compare.
// A later fetch goes through the queue, the emit state and the output registers; an
// empty fetch skips the emit state. Reset clears all control state; a two-entry queue
// lets commands arrive while the back end works, and busy holds them off when it is full.
module dirty_area_merge_and_band (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            cmd_i,
  input  dam_pkg::coord_t rect_x1_i,
  input  dam_pkg::coord_t rect_y1_i,
  input  dam_pkg::coord_t rect_x2_i,
  input  dam_pkg::coord_t rect_y2_i,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [dam_pkg::RowsBits-1:0] cfg_data_i,
  output logic            strobe_o,
  output dam_pkg::coord_t win_x1_o,
  output dam_pkg::coord_t win_y1_o,
  output dam_pkg::coord_t win_x2_o,
  output dam_pkg::coord_t win_y2_o,
  output logic            win_valid_o,
  output logic            win_last_o
);

  logic                 render_mode_q;
  logic [dam_pkg::RowsBits-1:0] max_rows_q;
  logic                 pop;
  logic                 item_valid;
  dam_pkg::item_t       item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      render_mode_q <= 1'b0;
      max_rows_q <= dam_pkg::RowsBits'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dam_pkg::RegRenderMode: render_mode_q <= cfg_data_i[0];
        dam_pkg::RegMaxRows: max_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dam_front u_front (
    .clk_i, .rst_ni, .start, .cmd_i, .rect_x1_i, .rect_y1_i, .rect_x2_i, .rect_y2_i,
    .busy, .pop_i(pop), .item_valid_o(item_valid), .item_o(item)
  );

  dam_back u_back (
    .clk_i, .rst_ni, .item_valid_i(item_valid), .item_i(item), .pop_o(pop),
    .render_mode_i(render_mode_q), .max_rows_i(max_rows_q), .strobe_o,
    .win_x1_o, .win_y1_o, .win_x2_o, .win_y2_o, .win_valid_o, .win_last_o
  );

endmodule

// ----- design/dam_front.sv -----
// Front end: accepts commands, orders rectangle corners and feeds the item queue.
module dam_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            cmd_i,
  input  dam_pkg::coord_t rect_x1_i,
  input  dam_pkg::coord_t rect_y1_i,
  input  dam_pkg::coord_t rect_x2_i,
  input  dam_pkg::coord_t rect_y2_i,
  output logic            busy,
  input  logic            pop_i,
  output logic            item_valid_o,
  output dam_pkg::item_t  item_o
);

  localparam int unsigned PtrBits = $clog2(dam_pkg::QueueDepth);

  dam_pkg::item_t       queue_q [dam_pkg::QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]     fill_q, fill_d;
  logic                 push;
  dam_pkg::item_t       item_in;

  assign busy = (fill_q == (PtrBits+1)'(dam_pkg::QueueDepth));
  assign push = start && !busy;
  assign item_valid_o = (fill_q != '0);
  assign item_o = queue_q[rd_ptr_q];

  always_comb begin
    item_in.fetch = (cmd_i == dam_pkg::CmdFetch);
    item_in.rect.x1 = (rect_x2_i < rect_x1_i) ? rect_x2_i : rect_x1_i;
    item_in.rect.x2 = (rect_x2_i < rect_x1_i) ? rect_x1_i : rect_x2_i;
    item_in.rect.y1 = (rect_y2_i < rect_y1_i) ? rect_y2_i : rect_y1_i;
    item_in.rect.y2 = (rect_y2_i < rect_y1_i) ? rect_y1_i : rect_y2_i;
    wr_ptr_d = push ? wr_ptr_q + PtrBits'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrBits'(1) : rd_ptr_q;
    fill_d = fill_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ----- design/dam_back.sv -----
// Back end: area store, join pass over area pairs and refresh window emission.
module dam_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  dam_pkg::item_t  item_i,
  output logic            pop_o,
  input  logic            render_mode_i,
  input  logic [dam_pkg::RowsBits-1:0] max_rows_i,
  output logic            strobe_o,
  output dam_pkg::coord_t win_x1_o,
  output dam_pkg::coord_t win_y1_o,
  output dam_pkg::coord_t win_x2_o,
  output dam_pkg::coord_t win_y2_o,
  output logic            win_valid_o,
  output logic            win_last_o
);

  localparam int unsigned IB = dam_pkg::IdxBits;
  localparam int unsigned CB = dam_pkg::CntBits;
  localparam int unsigned W = dam_pkg::CoordBits;

  dam_pkg::rect_t              store_q [dam_pkg::MaxAreas];
  logic [dam_pkg::MaxAreas-1:0] merged_q, merged_d;
  logic [CB-1:0]               count_q, count_d;
  logic                        join_done_q, join_done_d;
  logic [IB-1:0]               emit_q, emit_d;
  dam_pkg::coord_t             next_row_q, next_row_d;
  logic [CB-1:0]               ia_q, ia_d, ib_q, ib_d;
  dam_pkg::rect_t              ra_q, rb_q;
  logic [2*W+1:0]              box_sz_q, sum_sz_q;
  logic                        touch_q;
  dam_pkg::rect_t              box_q;
  dam_pkg::back_state_e        state_q, state_d;

  dam_pkg::rect_t box;
  dam_pkg::rect_t cur;
  logic [2*W+1:0] box_sz, a_sz, b_sz;
  logic           touch;
  logic           store_wr, store_box;
  logic [W:0]     rows, y2_full;
  dam_pkg::coord_t y1, y2;
  logic           more_rows;
  logic           out_fire, out_empty;
  logic           add_ok;

  assign add_ok = count_q < CB'(dam_pkg::MaxAreas);

  always_comb begin
    box.x1 = (ra_q.x1 < rb_q.x1) ? ra_q.x1 : rb_q.x1;
    box.y1 = (ra_q.y1 < rb_q.y1) ? ra_q.y1 : rb_q.y1;
    box.x2 = (ra_q.x2 > rb_q.x2) ? ra_q.x2 : rb_q.x2;
    box.y2 = (ra_q.y2 > rb_q.y2) ? ra_q.y2 : rb_q.y2;
    touch = ra_q.x1 <= rb_q.x2 && rb_q.x1 <= ra_q.x2 &&
            ra_q.y1 <= rb_q.y2 && rb_q.y1 <= ra_q.y2;
    box_sz = (2*W+2)'({1'b0, box.x2 - box.x1} + (W+1)'(1)) *
             (2*W+2)'({1'b0, box.y2 - box.y1} + (W+1)'(1));
    a_sz = (2*W+2)'({1'b0, ra_q.x2 - ra_q.x1} + (W+1)'(1)) *
           (2*W+2)'({1'b0, ra_q.y2 - ra_q.y1} + (W+1)'(1));
    b_sz = (2*W+2)'({1'b0, rb_q.x2 - rb_q.x1} + (W+1)'(1)) *
           (2*W+2)'({1'b0, rb_q.y2 - rb_q.y1} + (W+1)'(1));
  end

  always_comb begin
    cur = store_q[emit_q];
    rows = (max_rows_i == '0) ? (W+1)'(1) : max_rows_i[W:0];
    y1 = render_mode_i ? next_row_q : cur.y1;
    y2_full = {1'b0, next_row_q} + rows - (W+1)'(1);
    if (!render_mode_i || y2_full > {1'b0, cur.y2}) begin
      y2 = cur.y2;
    end else begin
      y2 = y2_full[W-1:0];
    end
    more_rows = render_mode_i && (y2 < cur.y2);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dam_pkg::StIdle: begin
        if (item_valid_i && item_i.fetch && count_q != '0) begin
          state_d = join_done_q ? dam_pkg::StEmit : dam_pkg::StJoinRead;
        end
      end
      dam_pkg::StJoinRead: begin
        if (ia_q >= count_q) begin
          state_d = dam_pkg::StFind;
        end else if (!merged_q[ia_q[IB-1:0]]) begin
          state_d = dam_pkg::StJoinTest;
        end
      end
      dam_pkg::StJoinTest: begin
        if (ib_q >= count_q) begin
          state_d = dam_pkg::StJoinRead;
        end
      end
      dam_pkg::StFind: begin
        if (ia_q >= count_q || !merged_q[ia_q[IB-1:0]]) begin
          state_d = dam_pkg::StEmit;
        end
      end
      dam_pkg::StEmit: state_d = dam_pkg::StIdle;
      default: state_d = dam_pkg::StIdle;
    endcase
  end

  // Each join test reads B, registers the box and sizes, then decides.
  logic [1:0] phase_q, phase_d;

  always_comb begin
    merged_d = merged_q;
    count_d = count_q;
    join_done_d = join_done_q;
    emit_d = emit_q;
    next_row_d = next_row_q;
    ia_d = ia_q;
    ib_d = ib_q;
    phase_d = phase_q;
    store_wr = 1'b0;
    store_box = 1'b0;
    pop_o = 1'b0;
    out_fire = 1'b0;
    out_empty = 1'b0;
    unique case (state_q)
      dam_pkg::StIdle: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (!item_i.fetch) begin
            if (add_ok) begin
              store_wr = 1'b1;
              merged_d[count_q[IB-1:0]] = 1'b0;
              count_d = count_q + CB'(1);
            end
          end else if (count_q == '0) begin
            out_fire = 1'b1;
            out_empty = 1'b1;
          end else begin
            ia_d = '0;
          end
        end
      end
      dam_pkg::StJoinRead: begin
        if (ia_q < count_q) begin
          if (merged_q[ia_q[IB-1:0]]) begin
            ia_d = ia_q + CB'(1);
          end else begin
            ib_d = '0;
            phase_d = 2'd0;
          end
        end else begin
          ia_d = '0;
          join_done_d = 1'b1;
        end
      end
      dam_pkg::StJoinTest: begin
        if (ib_q >= count_q) begin
          ia_d = ia_q + CB'(1);
        end else if (phase_q == 2'd0) begin
          phase_d = 2'd1;
        end else if (phase_q == 2'd1) begin
          phase_d = 2'd2;
        end else begin
          phase_d = 2'd0;
          if (touch_q && !merged_q[ib_q[IB-1:0]] && ib_q != ia_q &&
              box_sz_q < sum_sz_q) begin
            store_box = 1'b1;
            merged_d[ib_q[IB-1:0]] = 1'b1;
          end
          ib_d = ib_q + CB'(1);
        end
      end
      dam_pkg::StFind: begin
        if (ia_q >= count_q || !merged_q[ia_q[IB-1:0]]) begin
          emit_d = ia_q[IB-1:0];
          next_row_d = store_q[ia_q[IB-1:0]].y1;
        end else begin
          ia_d = ia_q + CB'(1);
        end
      end
      dam_pkg::StEmit: begin
        out_fire = 1'b1;
        if (more_rows) begin
          next_row_d = y2 + W'(1);
        end else begin
          ia_d = {1'b0, emit_q} + CB'(1);
        end
      end
      default: ;
    endcase
  end

  // Search for the next unmerged area after the one being emitted.
  logic          nxt_found;
  logic [IB-1:0] nxt_idx;
  always_comb begin
    nxt_found = 1'b0;
    nxt_idx = '0;
    for (int i = dam_pkg::MaxAreas - 1; i >= 0; i--) begin
      if (CB'(i) > {1'b0, emit_q} && CB'(i) < count_q && !merged_q[i]) begin
        nxt_found = 1'b1;
        nxt_idx = IB'(i);
      end
    end
  end

  logic clear;
  assign clear = (state_q == dam_pkg::StEmit) && !more_rows && !nxt_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dam_pkg::StIdle;
      merged_q <= '0;
      count_q <= '0;
      join_done_q <= 1'b0;
      emit_q <= '0;
      next_row_q <= '0;
      ia_q <= '0;
      ib_q <= '0;
      phase_q <= 2'd0;
      strobe_o <= 1'b0;
      win_valid_o <= 1'b0;
      win_last_o <= 1'b0;
    end else begin
      state_q <= state_d;
      ia_q <= ia_d;
      ib_q <= ib_d;
      phase_q <= phase_d;
      strobe_o <= out_fire;
      win_valid_o <= out_fire && !out_empty;
      win_last_o <= clear;
      if (clear) begin
        merged_q <= '0;
        count_q <= '0;
        join_done_q <= 1'b0;
        emit_q <= '0;
        next_row_q <= '0;
      end else if (state_q == dam_pkg::StEmit && !more_rows) begin
        merged_q <= merged_d;
        count_q <= count_d;
        join_done_q <= join_done_d;
        emit_q <= nxt_idx;
        next_row_q <= store_q[nxt_idx].y1;
      end else begin
        merged_q <= merged_d;
        count_q <= count_d;
        join_done_q <= join_done_d;
        emit_q <= emit_d;
        next_row_q <= next_row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[count_q[IB-1:0]] <= item_i.rect;
    end
    if (store_box) begin
      store_q[ia_q[IB-1:0]] <= box_q;
      ra_q <= box_q;
    end else if (state_q == dam_pkg::StJoinRead && ia_q < count_q) begin
      ra_q <= store_q[ia_q[IB-1:0]];
    end
    if (state_q == dam_pkg::StJoinTest && phase_q == 2'd0 && ib_q < count_q) begin
      rb_q <= store_q[ib_q[IB-1:0]];
    end
    touch_q <= touch;
    box_q <= box;
    box_sz_q <= box_sz;
    sum_sz_q <= a_sz + b_sz;
    if (out_fire) begin
      win_x1_o <= out_empty ? '0 : cur.x1;
      win_y1_o <= out_empty ? '0 : y1;
      win_x2_o <= out_empty ? '0 : cur.x2;
      win_y2_o <= out_empty ? '0 : y2;
    end
  end

endmodule

// ----- design/dam_checker.sv -----
// Port-level checker for the dirty area merge block, bound to the top level.
module dam_port_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            strobe_i,
  input logic            win_valid_i,
  input logic            win_last_i,
  input dam_pkg::coord_t win_y1_i,
  input dam_pkg::coord_t win_y2_i
);

  a_last_needs_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_last_i |-> strobe_i && win_valid_i) else $error("last without window");

  a_valid_needs_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid_i |-> strobe_i) else $error("valid without strobe");

  a_rows_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid_i |-> win_y1_i <= win_y2_i) else $error("window rows inverted");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_i && !win_valid_i |-> win_y1_i == '0 && win_y2_i == '0)
    else $error("empty window with nonzero rows");

endmodule

bind dirty_area_merge_and_band dam_port_checker u_dam_port_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .strobe_i(strobe_o), .win_valid_i(win_valid_o),
  .win_last_i(win_last_o), .win_y1_i(win_y1_o), .win_y2_i(win_y2_o)
);
